FILE: design/psla_pkg.sv
`timescale 1ns / 1ps
package psla_pkg;

  localparam int COORD_W      = 24;
  localparam int N_W          = 11;
  localparam int SX_W         = 34;
  localparam int SXX_W        = 57;
  localparam int SXY_W        = 58;
  localparam int ACC_W        = 72;
  localparam int NORM_BITS    = 41;
  localparam int CW           = 44;
  localparam int ZW           = 63;
  localparam int TH_W         = 62;
  localparam int T32_W        = 34;
  localparam int DVD_W        = 58;
  localparam int ANGLE_W      = 24;
  localparam int CORDIC_STEPS = 48;
  localparam int STEP_W       = 6;

  localparam logic [63:0] Q_ONE = 64'd1 << 60;
  localparam logic [ANGLE_W-1:0] DEG_SCALE = 24'd11796480;

  typedef logic [63:0] atan_tab_t [CORDIC_STEPS];

  // Machin formula, evaluated in Q60 with truncating integer series.
  function automatic logic [63:0] calc_pi_q60();
    logic [63:0] p5;
    logic [63:0] p239;
    logic [63:0] a5;
    logic [63:0] a239;
    logic [63:0] t5;
    logic [63:0] t239;
    p5   = Q_ONE / 5;
    p239 = Q_ONE / 239;
    a5   = '0;
    a239 = '0;
    for (int k = 0; k < 32; k++) begin
      t5   = p5 / 64'(2 * k + 1);
      t239 = p239 / 64'(2 * k + 1);
      if (k % 2 == 0) begin
        a5   = a5 + t5;
        a239 = a239 + t239;
      end else begin
        a5   = a5 - t5;
        a239 = a239 - t239;
      end
      p5   = p5 / 25;
      p239 = p239 / 57121;
    end
    return (64'd16 * a5) - (64'd4 * a239);
  endfunction

  localparam logic [63:0] PI_Q60      = calc_pi_q60();
  localparam logic [63:0] HALF_PI_Q60 = PI_Q60 >> 1;
  localparam logic [T32_W-1:0] P32      = T32_W'(PI_Q60 >> 28);
  localparam logic [T32_W-1:0] P32_HALF = P32 / 2;

  // atan(2^-i) in Q60 by its power series.
  function automatic logic [63:0] atan_pow2(input int unsigned i);
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] term;
    p   = Q_ONE >> i;
    acc = '0;
    for (int k = 0; k < 32; k++) begin
      term = p / 64'(2 * k + 1);
      if (k % 2 == 0) begin
        acc = acc + term;
      end else begin
        acc = acc - term;
      end
      p = (2 * i < 64) ? (p >> (2 * i)) : '0;
    end
    return acc;
  endfunction

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t tab;
    tab[0] = PI_Q60 >> 2;
    for (int unsigned i = 1; i < CORDIC_STEPS; i++) begin
      tab[i] = atan_pow2(i);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

  typedef struct packed {
    logic [N_W-1:0]          n;
    logic signed [SX_W-1:0]  sx;
    logic signed [SX_W-1:0]  sy;
    logic signed [SXX_W-1:0] sxx;
    logic signed [SXX_W-1:0] syy;
    logic signed [SXY_W-1:0] sxy;
    logic                    steep;
    logic                    ovf;
  } psla_sums_t;

  typedef struct packed {
    logic [NORM_BITS-1:0] mag;
    logic [NORM_BITS-1:0] den;
    logic                 neg;
    logic                 degen;
  } psla_norm_t;

endpackage

FILE: design/point_set_line_angle.sv
`timescale 1ns / 1ps
// Channel   | Direction | Ports                                        | Handshake
// ----------+-----------+----------------------------------------------+---------------------
// point in  | input     | x_coord_i, y_coord_i, last_point_i           | start_i && !busy_o
// result    | output    | angle_deg_o, steep_o, degenerate_o,          | done_o, one cycle
//           |           | too_many_o, points_used_o                    |
//
// Points are taken one word per cycle while busy_o is low; the sums run in a
// three-stage pipeline. A word with last_point_i raises busy_o until the result.
// After the last word the sum pipeline drains, then the serial shift-add
// multiplier, one sign check, the normalization, 48 CORDIC steps and the
// degree scaling and the reciprocal division by pi run in turn; a degenerate
// set ends after the sign check. Reset clears the sums and the sequencers
// and takes effect at once. done_o is a pulse the receiver cannot hold off.
module point_set_line_angle import psla_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [COORD_W-1:0] x_coord_i,
  input  logic [COORD_W-1:0] y_coord_i,
  input  logic               last_point_i,
  output logic               done_o,
  output logic [ANGLE_W-1:0] angle_deg_o,
  output logic               steep_o,
  output logic               degenerate_o,
  output logic               too_many_o,
  output logic [N_W-1:0]     points_used_o
);

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_DRAIN = 2'd1;
  localparam logic [1:0] T_SLOPE = 2'd2;
  localparam logic [1:0] T_ROT   = 2'd3;

  logic [1:0] state_q, state_d;
  logic accept, drained, slope_start, slope_done, cordic_start, cordic_done, emit;
  logic done_q;
  psla_sums_t sums;
  psla_norm_t norm;
  logic [ANGLE_W-1:0] cordic_angle, angle_q;
  logic steep_q, degen_q, too_many_q;
  logic [N_W-1:0] used_q;

  assign busy_o = (state_q != T_IDLE);
  assign accept = start_i & ~busy_o;

  psla_accum #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .last_point_i(last_point_i),
    .clear_i     (emit),
    .sums_o      (sums),
    .drained_o   (drained)
  );

  psla_slope u_slope (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(slope_start),
    .sums_i (sums),
    .done_o (slope_done),
    .norm_o (norm)
  );

  psla_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cordic_start),
    .norm_i (norm),
    .steep_i(sums.steep),
    .done_o (cordic_done),
    .angle_o(cordic_angle)
  );

  // The sequencer waits for the last point to leave the sum pipeline, then
  // runs the slope terms and, unless the set is degenerate, the angle unit.
  always_comb begin
    state_d      = state_q;
    slope_start  = 1'b0;
    cordic_start = 1'b0;
    emit         = 1'b0;
    case (state_q)
      T_IDLE: begin
        if (accept && last_point_i) state_d = T_DRAIN;
      end
      T_DRAIN: begin
        if (drained) begin
          slope_start = 1'b1;
          state_d     = T_SLOPE;
        end
      end
      T_SLOPE: begin
        if (slope_done) begin
          if (norm.degen) begin
            emit    = 1'b1;
            state_d = T_IDLE;
          end else begin
            cordic_start = 1'b1;
            state_d      = T_ROT;
          end
        end
      end
      T_ROT: begin
        if (cordic_done) begin
          emit    = 1'b1;
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= emit;
    end
  end

  // The result is captured in the same cycle that clears the sums for the
  // next set.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      angle_q    <= norm.degen ? '0 : cordic_angle;
      steep_q    <= sums.steep;
      degen_q    <= norm.degen;
      too_many_q <= sums.ovf;
      used_q     <= sums.n;
    end
  end

  assign done_o        = done_q;
  assign angle_deg_o   = angle_q;
  assign steep_o       = steep_q;
  assign degenerate_o  = degen_q;
  assign too_many_o    = too_many_q;
  assign points_used_o = used_q;

endmodule

FILE: design/psla_accum.sv
`timescale 1ns / 1ps
module psla_accum import psla_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [COORD_W-1:0] x_coord_i,
  input  logic [COORD_W-1:0] y_coord_i,
  input  logic               last_point_i,
  input  logic               clear_i,
  output psla_sums_t         sums_o,
  output logic               drained_o
);

  logic [N_W-1:0] cnt_q;
  logic ovf_q;
  logic use_pt;
  logic a_vld_q, a_first_q, a_last_q, b_vld_q, b_last_q, c_last_q;
  logic signed [COORD_W-1:0] xs, ys, xa_q, ya_q;
  logic signed [2*COORD_W-1:0] pxx_q, pyy_q, pxy_q;
  logic signed [SX_W-1:0] sx_q, sy_q;
  logic signed [SXX_W-1:0] sxx_q, syy_q;
  logic signed [SXY_W-1:0] sxy_q;
  logic signed [COORD_W-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic signed [COORD_W:0] x_span, y_span;

  assign xs = COORD_W'(signed'(x_coord_i[COORD_BITS-1:0]));
  assign ys = COORD_W'(signed'(y_coord_i[COORD_BITS-1:0]));
  assign use_pt = (cnt_q < N_W'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      a_vld_q  <= 1'b0;
      a_last_q <= 1'b0;
      b_vld_q  <= 1'b0;
      b_last_q <= 1'b0;
      c_last_q <= 1'b0;
      sx_q     <= '0;
      sy_q     <= '0;
      sxx_q    <= '0;
      syy_q    <= '0;
      sxy_q    <= '0;
    end else begin
      a_vld_q  <= accept_i & use_pt;
      a_last_q <= accept_i & last_point_i;
      b_vld_q  <= a_vld_q;
      b_last_q <= a_last_q;
      c_last_q <= b_last_q;
      if (clear_i) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        syy_q <= '0;
        sxy_q <= '0;
      end else begin
        if (accept_i) begin
          if (use_pt) begin
            cnt_q <= cnt_q + N_W'(1);
          end else begin
            ovf_q <= 1'b1;
          end
        end
        if (a_vld_q) begin
          sx_q <= sx_q + SX_W'(xa_q);
          sy_q <= sy_q + SX_W'(ya_q);
        end
        if (b_vld_q) begin
          sxx_q <= sxx_q + SXX_W'(pxx_q);
          syy_q <= syy_q + SXX_W'(pyy_q);
          sxy_q <= sxy_q + SXY_W'(pxy_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      xa_q      <= xs;
      ya_q      <= ys;
      a_first_q <= (cnt_q == '0);
    end
    if (a_vld_q) begin
      pxx_q <= xa_q * xa_q;
      pyy_q <= ya_q * ya_q;
      pxy_q <= xa_q * ya_q;
      if (a_first_q || xa_q < xmin_q) xmin_q <= xa_q;
      if (a_first_q || xa_q > xmax_q) xmax_q <= xa_q;
      if (a_first_q || ya_q < ymin_q) ymin_q <= ya_q;
      if (a_first_q || ya_q > ymax_q) ymax_q <= ya_q;
    end
  end

  assign x_span = (COORD_W+1)'(xmax_q) - (COORD_W+1)'(xmin_q);
  assign y_span = (COORD_W+1)'(ymax_q) - (COORD_W+1)'(ymin_q);

  assign sums_o.n     = cnt_q;
  assign sums_o.sx    = sx_q;
  assign sums_o.sy    = sy_q;
  assign sums_o.sxx   = sxx_q;
  assign sums_o.syy   = syy_q;
  assign sums_o.sxy   = sxy_q;
  assign sums_o.steep = (y_span > x_span);
  assign sums_o.ovf   = ovf_q;
  assign drained_o    = c_last_q;

endmodule

FILE: design/psla_slope.sv
`timescale 1ns / 1ps
module psla_slope import psla_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  psla_sums_t sums_i,
  output logic       done_o,
  output psla_norm_t norm_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_MAG  = 2'd2;
  localparam logic [1:0] S_NORM = 2'd3;

  // Product phases: n*Sxy, -Sx*Sy, n*S2, -Sa*Sa. Odd phases subtract.
  localparam logic [1:0] PH_NXY = 2'd0;
  localparam logic [1:0] PH_XY  = 2'd1;
  localparam logic [1:0] PH_NSQ = 2'd2;
  localparam logic [1:0] PH_SQ  = 2'd3;

  localparam logic [5:0] LEN_N = 6'(N_W + 1);
  localparam logic [5:0] LEN_S = 6'(SX_W);

  logic [1:0] state_q, state_d, phase_q, phase_d, ld_phase;
  logic [5:0] cnt_q, cnt_d, len;
  logic signed [ACC_W-1:0] acc_q, acc_d, num_q, num_d;
  logic [ACC_W-1:0] mcand_q, mcand_d, ld_mcand, addend, acc_sum, acc_step, both;
  logic [SX_W-1:0] mplier_q, mplier_d, ld_mplier;
  logic neg_q, neg_d, degen_q, degen_d, done_q, done_d;
  logic last_bit, sub;
  logic signed [SX_W-1:0] sa;
  logic signed [SXX_W-1:0] s2;

  assign sa = sums_i.steep ? sums_i.sy : sums_i.sx;
  assign s2 = sums_i.steep ? sums_i.syy : sums_i.sxx;
  assign ld_phase = (state_q == S_IDLE) ? PH_NXY : phase_q + 2'd1;

  always_comb begin
    case (ld_phase)
      PH_NXY: begin
        ld_mcand  = ACC_W'(sums_i.sxy);
        ld_mplier = SX_W'(sums_i.n);
      end
      PH_XY: begin
        ld_mcand  = ACC_W'(sums_i.sx);
        ld_mplier = sums_i.sy;
      end
      PH_NSQ: begin
        ld_mcand  = ACC_W'(s2);
        ld_mplier = SX_W'(sums_i.n);
      end
      default: begin
        ld_mcand  = ACC_W'(sa);
        ld_mplier = sa;
      end
    endcase
  end

  // The shared adder: one signed shift-add step per cycle; the top bit of a
  // signed multiplier carries negative weight, so its step flips the sign.
  assign len      = phase_q[0] ? LEN_S : LEN_N;
  assign last_bit = (cnt_q == len - 6'd1);
  assign sub      = phase_q[0] ^ last_bit;
  assign addend   = sub ? ~mcand_q : mcand_q;
  assign acc_sum  = acc_q + addend + ACC_W'(sub);
  assign acc_step = mplier_q[0] ? acc_sum : acc_q;
  assign both     = num_q | acc_q;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    num_d    = num_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    neg_d    = neg_q;
    degen_d  = degen_q;
    done_d   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          acc_d    = '0;
          phase_d  = PH_NXY;
          cnt_d    = '0;
          mcand_d  = ld_mcand;
          mplier_d = ld_mplier;
          degen_d  = 1'b0;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        acc_d    = acc_step;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + 6'd1;
        if (last_bit) begin
          cnt_d    = '0;
          phase_d  = phase_q + 2'd1;
          mcand_d  = ld_mcand;
          mplier_d = ld_mplier;
          if (phase_q == PH_XY) begin
            num_d = acc_step;
            acc_d = '0;
          end
          if (phase_q == PH_SQ) begin
            state_d = S_MAG;
          end
        end
      end
      S_MAG: begin
        if (acc_q[ACC_W-1] || acc_q == '0) begin
          degen_d = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          neg_d = num_q[ACC_W-1];
          if (num_q[ACC_W-1]) num_d = -num_q;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        // One bit per cycle until the larger operand's top bit sits at
        // position NORM_BITS-1. Right shifts truncate, as one wide shift would.
        if (|both[ACC_W-1:NORM_BITS]) begin
          num_d = num_q >>> 1;
          acc_d = acc_q >>> 1;
        end else if (!both[NORM_BITS-1]) begin
          num_d = num_q <<< 1;
          acc_d = acc_q <<< 1;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_NXY;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    num_q    <= num_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    neg_q    <= neg_d;
    degen_q  <= degen_d;
  end

  assign done_o       = done_q;
  assign norm_o.mag   = num_q[NORM_BITS-1:0];
  assign norm_o.den   = acc_q[NORM_BITS-1:0];
  assign norm_o.neg   = neg_q;
  assign norm_o.degen = degen_q;

endmodule

FILE: design/psla_cordic.sv
`timescale 1ns / 1ps
module psla_cordic import psla_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  psla_norm_t         norm_i,
  input  logic               steep_i,
  output logic               done_o,
  output logic [ANGLE_W-1:0] angle_o
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_ROT  = 3'd1;
  localparam logic [2:0] C_TH   = 3'd2;
  localparam logic [2:0] C_MUL  = 3'd3;
  localparam logic [2:0] C_ADD  = 3'd4;
  localparam logic [2:0] C_EST  = 3'd5;
  localparam logic [2:0] C_REM  = 3'd6;
  localparam logic [2:0] C_FIX  = 3'd7;

  localparam int RCP_W = 25;
  localparam int EST_W = T32_W + RCP_W;
  localparam int REM_W = T32_W + 2;

  localparam logic signed [ZW-1:0] HALF_Z = ZW'(HALF_PI_Q60);
  localparam logic [TH_W-1:0] HALF_TH = TH_W'(HALF_PI_Q60);
  localparam logic [TH_W-1:0] PI_TH   = TH_W'(PI_Q60);
  // Reciprocal of pi in Q26, scaled so that the top dividend bits times it
  // land the quotient estimate at bit T32_W. The estimate is at most two low.
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << DVD_W) / 64'(P32));

  logic [2:0] state_q, state_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [ZW-1:0] z_q, z_d, atan_z;
  logic [STEP_W-1:0] i_q, i_d;
  logic [TH_W-1:0] phi, theta, theta_q, theta_d;
  logic [DVD_W-1:0] dvd_q, dvd_d, add_sum, q_prod, rem_diff;
  logic [EST_W-1:0] est_prod;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [ANGLE_W-1:0] quo_q, quo_d;
  logic done_q, done_d, ge;

  assign dx     = x_q >>> i_q;
  assign dy     = y_q >>> i_q;
  assign atan_z = ZW'(ATAN_TAB[i_q]);

  assign phi = (z_q < 0) ? '0 : ((z_q > HALF_Z) ? HALF_TH : z_q[TH_W-1:0]);
  always_comb begin
    if (steep_i) begin
      theta = norm_i.neg ? PI_TH - phi : phi;
    end else begin
      theta = norm_i.neg ? HALF_TH + phi : HALF_TH - phi;
    end
  end

  assign add_sum  = dvd_q + DVD_W'(P32_HALF);
  assign est_prod = EST_W'(dvd_q[DVD_W-1:ANGLE_W]) * EST_W'(RECIP);
  assign q_prod   = DVD_W'(quo_q) * DVD_W'(P32);
  assign rem_diff = dvd_q - q_prod;
  assign ge       = (rem_q >= REM_W'(P32));

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    i_d     = i_q;
    theta_d = theta_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    done_d  = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          x_d     = CW'(norm_i.den);
          y_d     = CW'(norm_i.mag);
          z_d     = '0;
          i_d     = '0;
          state_d = C_ROT;
        end
      end
      C_ROT: begin
        // Vectoring: drive y toward zero; once it is zero the rest is idle.
        if (y_q != 0) begin
          if (!y_q[CW-1]) begin
            x_d = x_q + dy;
            y_d = y_q - dx;
            z_d = z_q + atan_z;
          end else begin
            x_d = x_q - dy;
            y_d = y_q + dx;
            z_d = z_q - atan_z;
          end
        end
        i_d = i_q + STEP_W'(1);
        if (i_q == STEP_W'(CORDIC_STEPS - 1)) state_d = C_TH;
      end
      C_TH: begin
        theta_d = theta;
        state_d = C_MUL;
      end
      C_MUL: begin
        dvd_d   = DVD_W'(theta_q[TH_W-1:28]) * DVD_W'(DEG_SCALE);
        state_d = C_ADD;
      end
      C_ADD: begin
        dvd_d   = add_sum;
        state_d = C_EST;
      end
      C_EST: begin
        quo_d   = est_prod[T32_W+ANGLE_W-1:T32_W];
        state_d = C_REM;
      end
      C_REM: begin
        rem_d   = rem_diff[REM_W-1:0];
        state_d = C_FIX;
      end
      C_FIX: begin
        // At most two corrections bring the remainder below pi in Q32.
        if (ge) begin
          rem_d = rem_q - REM_W'(P32);
          quo_d = quo_q + ANGLE_W'(1);
        end else begin
          done_d  = 1'b1;
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      i_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    theta_q <= theta_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
  end

  assign done_o  = done_q;
  assign angle_o = quo_q;

endmodule

FILE: design/psla_checker.sv
`timescale 1ns / 1ps
module psla_checker import psla_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [COORD_W-1:0] x_coord_i,
  input logic [COORD_W-1:0] y_coord_i,
  input logic               last_point_i,
  input logic               done_o,
  input logic [ANGLE_W-1:0] angle_deg_o,
  input logic               steep_o,
  input logic               degenerate_o,
  input logic               too_many_o,
  input logic [N_W-1:0]     points_used_o
);

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_point_i) |=> (busy_o && !done_o))
    else $error("closing word did not make the block busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (points_used_o != '0 && points_used_o <= N_W'(MAX_POINTS)))
    else $error("points_used out of range");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (angle_deg_o == '0))
    else $error("degenerate result with nonzero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (angle_deg_o <= DEG_SCALE))
    else $error("angle above half a turn");

endmodule

bind point_set_line_angle psla_checker #(.MAX_POINTS(MAX_POINTS)) u_psla_checker (.*);
